// ===== rtl/core/ptc_pkg.sv =====
// shared types, constants and helpers for the pressure/temperature compensation block
// used by every module under rtl/core; depends on nothing else
`timescale 1ns / 1ps

package ptc_pkg;

  // field and bus widths
  localparam int RawW   = 20;
  localparam int TempW  = 24;
  localparam int PressW = 32;
  localparam int DataW  = 64;
  localparam int AddrW  = 6;
  localparam int DivSteps = 64;

  // compensation constants
  localparam int FineOffset = 128000;
  localparam int DivScale   = 3125;
  localparam int PressBase  = 1048576;

  // register reset values
  localparam int TempLoReset  = -1000;
  localparam int TempHiReset  = 5000;
  localparam int PressLoReset = 23040000;
  localparam int PressHiReset = 28160000;

  // register map, one 64-bit slot each
  typedef enum logic [2:0] {
    REG_TEMP_COEFFS  = 3'd0,
    REG_PRESS_A      = 3'd1,
    REG_PRESS_B      = 3'd2,
    REG_PRESS_C      = 3'd3,
    REG_TEMP_LO      = 3'd4,
    REG_TEMP_HI      = 3'd5,
    REG_PRESS_LO     = 3'd6,
    REG_PRESS_HI     = 3'd7
  } ptc_reg_t;

  // calibration words
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } ptc_coef_t;

  // plausibility window
  typedef struct packed {
    logic signed [15:0]       temp_lo;
    logic signed [15:0]       temp_hi;
    logic        [PressW-1:0] press_lo;
    logic        [PressW-1:0] press_hi;
  } ptc_limits_t;

  // sideband that rides along the divider
  typedef struct packed {
    logic signed [TempW-1:0] tc;
    logic                    zero;
  } ptc_tag_t;

  // front end to divider
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
    ptc_tag_t         tag;
  } ptc_div_in_t;

  // divider to back end
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] quo;
    ptc_tag_t         tag;
  } ptc_div_out_t;

  // low 64 bits of a 64 x signed 16 product
  function automatic logic [DataW-1:0] mul_lo64_s16(logic [DataW-1:0] a,
                                                    logic signed [15:0] b);
    logic signed [DataW+15:0] m;
    m = $signed(a) * b;
    return m[DataW-1:0];
  endfunction

endpackage

// ===== rtl/core/pressure_temp_compensation.sv =====
// top level of the barometric compensation block: register port and the
// front, divider and back pipeline; uses ptc_pkg, ptc_front, ptc_div, ptc_back
//
// Usage
//   Input: present in_raw_temperature and in_raw_pressure with start high;
//   the word is taken at the rising edge where start is high and busy low.
//   busy never rises, so a new word can be taken in every cycle.
//   Output: each word yields one result (temperature, pressure, abnormal)
//   shown for exactly one cycle with out_valid high, in input order.
//   Throughput is one word per cycle; the pipeline is the 9-stage
//   polynomial front end, the 66-stage bit-per-stage divider and the
//   6-stage correction back end.
//   Registers: 64-bit slots at byte address 8*index, written in the APB
//   access phase; pready is always high. Write them only while no word is
//   in flight.
//   Reset: synchronous active-low rst_n clears all valid bits and loads
//   the register reset values; words in flight are dropped.
//   The receiver cannot stall: results are never held back.
`timescale 1ns / 1ps

module pressure_temp_compensation (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ptc_pkg::RawW-1:0]         in_raw_temperature,
  input  logic [ptc_pkg::RawW-1:0]         in_raw_pressure,
  output logic                             out_valid,
  output logic signed [ptc_pkg::TempW-1:0] out_temperature_centi,
  output logic [ptc_pkg::PressW-1:0]       out_pressure_q8,
  output logic                             out_abnormal,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ptc_pkg::AddrW-1:0]        paddr,
  input  logic [ptc_pkg::DataW-1:0]        pwdata,
  output logic [ptc_pkg::DataW-1:0]        prdata,
  output logic                             pready
);
  import ptc_pkg::*;

  logic [47:0]       temp_coeffs_r, press_a_r, press_b_r, press_c_r;
  logic [15:0]       temp_lo_r, temp_hi_r;
  logic [PressW-1:0] press_lo_r, press_hi_r;
  ptc_reg_t          reg_sel;
  logic              wr_en;
  ptc_coef_t         coef;
  ptc_limits_t       limits;
  ptc_div_in_t       div_in;
  ptc_div_out_t      div_out;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_sel = ptc_reg_t'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_c_r     <= '0;
      temp_lo_r     <= 16'(TempLoReset);
      temp_hi_r     <= 16'(TempHiReset);
      press_lo_r    <= PressW'(PressLoReset);
      press_hi_r    <= PressW'(PressHiReset);
    end else if (wr_en) begin
      case (reg_sel)
        REG_TEMP_COEFFS: temp_coeffs_r <= pwdata[47:0];
        REG_PRESS_A:     press_a_r     <= pwdata[47:0];
        REG_PRESS_B:     press_b_r     <= pwdata[47:0];
        REG_PRESS_C:     press_c_r     <= pwdata[47:0];
        REG_TEMP_LO:     temp_lo_r     <= pwdata[15:0];
        REG_TEMP_HI:     temp_hi_r     <= pwdata[15:0];
        REG_PRESS_LO:    press_lo_r    <= pwdata[PressW-1:0];
        REG_PRESS_HI:    press_hi_r    <= pwdata[PressW-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      REG_TEMP_COEFFS: prdata = {16'd0, temp_coeffs_r};
      REG_PRESS_A:     prdata = {16'd0, press_a_r};
      REG_PRESS_B:     prdata = {16'd0, press_b_r};
      REG_PRESS_C:     prdata = {16'd0, press_c_r};
      REG_TEMP_LO:     prdata = {48'd0, temp_lo_r};
      REG_TEMP_HI:     prdata = {48'd0, temp_hi_r};
      REG_PRESS_LO:    prdata = {32'd0, press_lo_r};
      REG_PRESS_HI:    prdata = {32'd0, press_hi_r};
      default:         prdata = '0;
    endcase
  end

  // unpack calibration words and limits
  always_comb begin
    coef.t1 = temp_coeffs_r[15:0];
    coef.t2 = temp_coeffs_r[31:16];
    coef.t3 = temp_coeffs_r[47:32];
    coef.p1 = press_a_r[15:0];
    coef.p2 = press_a_r[31:16];
    coef.p3 = press_a_r[47:32];
    coef.p4 = press_b_r[15:0];
    coef.p5 = press_b_r[31:16];
    coef.p6 = press_b_r[47:32];
    coef.p7 = press_c_r[15:0];
    coef.p8 = press_c_r[31:16];
    coef.p9 = press_c_r[47:32];
    limits.temp_lo  = temp_lo_r;
    limits.temp_hi  = temp_hi_r;
    limits.press_lo = press_lo_r;
    limits.press_hi = press_hi_r;
  end

  ptc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .raw_t    (in_raw_temperature),
    .raw_p    (in_raw_pressure),
    .coef     (coef),
    .div_in   (div_in)
  );

  ptc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_in  (div_in),
    .div_out (div_out)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_out   (div_out),
    .coef      (coef),
    .limits    (limits),
    .out_valid (out_valid),
    .out_temp  (out_temperature_centi),
    .out_press (out_pressure_q8),
    .out_bad   (out_abnormal)
  );

endmodule

// ===== rtl/core/ptc_front.sv =====
// front end: fine temperature, compensated temperature and the pressure
// polynomial up to the divider operands; uses ptc_pkg
`timescale 1ns / 1ps

module ptc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [ptc_pkg::RawW-1:0] raw_t,
  input  logic [ptc_pkg::RawW-1:0] raw_p,
  input  ptc_pkg::ptc_coef_t       coef,
  output ptc_pkg::ptc_div_in_t     div_in
);
  import ptc_pkg::*;

  logic [8:0] vld_r;

  // stage 1
  logic signed [18:0] dt1;
  logic signed [16:0] dd_d;
  logic signed [33:0] dd_full;
  logic signed [34:0] s1_a1p_nxt, s1_a1p_r;
  logic [32:0]        s1_dd_r;
  logic [20:0]        s1_pp_nxt, s1_pp_r;
  // stage 2
  logic signed [23:0] s2_a1_r;
  logic signed [37:0] s2_a2p_nxt, s2_a2p_r;
  logic [20:0]        s2_pp_r;
  // stage 3
  logic signed [23:0] a2;
  logic signed [24:0] s3_fine_nxt, s3_fine_r;
  logic [20:0]        s3_pp_r;
  // stage 4
  logic signed [28:0] f5;
  logic signed [TempW-1:0] s4_tc_nxt, s4_tc_r;
  logic signed [25:0] s4_v1_nxt, s4_v1_r;
  logic [20:0]        s4_pp_r;
  // stage 5
  logic signed [51:0] s5_vv_nxt, s5_vv_r;
  logic signed [41:0] s5_vp5_nxt, s5_vp5_r, s5_vp2_nxt, s5_vp2_r;
  logic signed [TempW-1:0] s5_tc_r;
  logic [20:0]        s5_pp_r;
  // stage 6
  logic [DataW-1:0]   s6_v2a_nxt, s6_v2a_r, s6_v2b_nxt, s6_v2b_r;
  logic [DataW-1:0]   s6_acca_nxt, s6_acca_r, s6_accb_nxt, s6_accb_r;
  logic [DataW-1:0]   vv_ext;
  logic signed [TempW-1:0] s6_tc_r;
  logic [20:0]        s6_pp_r;
  // stage 7
  logic [DataW-1:0]   s7_v2_nxt, s7_v2_r, s7_acc0_nxt, s7_acc0_r;
  logic signed [TempW-1:0] s7_tc_r;
  logic [20:0]        s7_pp_r;
  // stage 8
  logic [DataW-1:0]   s8_accm_nxt, s8_accm_r, s8_numa_nxt, s8_numa_r;
  logic signed [TempW-1:0] s8_tc_r;
  // stage 9
  logic [DataW-1:0]   s9_num_nxt, s9_num_r, s9_den_nxt, s9_den_r;
  logic               s9_zero_nxt, s9_zero_r;
  logic signed [TempW-1:0] s9_tc_r;

  // stage 1: first temperature products
  assign dt1        = $signed({2'b00, raw_t[RawW-1:3]}) - $signed({2'b00, coef.t1, 1'b0});
  assign s1_a1p_nxt = dt1 * coef.t2;
  assign dd_d       = $signed({1'b0, raw_t[RawW-1:4]}) - $signed({1'b0, coef.t1});
  assign dd_full    = dd_d * dd_d;
  assign s1_pp_nxt  = 21'(PressBase) - {1'b0, raw_p};

  // stage 2: second temperature product
  assign s2_a2p_nxt = $signed({1'b0, s1_dd_r[32:12]}) * coef.t3;

  // stage 3: fine temperature
  assign a2          = s2_a2p_r[37:14];
  assign s3_fine_nxt = $signed({s2_a1_r[23], s2_a1_r}) + $signed({a2[23], a2});

  // stage 4: temperature in 0.01 degC and pressure offset
  assign f5        = $signed({{4{s3_fine_r[24]}}, s3_fine_r}) * 29'sd5 + 29'sd128;
  assign s4_tc_nxt = {{3{f5[28]}}, f5[28:8]};
  assign s4_v1_nxt = $signed({s3_fine_r[24], s3_fine_r}) - $signed(26'(FineOffset));

  // stage 5: offset square and linear terms
  assign s5_vv_nxt  = s4_v1_r * s4_v1_r;
  assign s5_vp5_nxt = s4_v1_r * coef.p5;
  assign s5_vp2_nxt = s4_v1_r * coef.p2;

  // stage 6: square terms and shifted linear terms
  assign vv_ext      = {{12{s5_vv_r[51]}}, s5_vv_r};
  assign s6_v2a_nxt  = mul_lo64_s16(vv_ext, coef.p6);
  assign s6_acca_nxt = mul_lo64_s16(vv_ext, coef.p3);
  assign s6_v2b_nxt  = ({{22{s5_vp5_r[41]}}, s5_vp5_r} << 17)
                     + ({{48{coef.p4[15]}}, coef.p4} << 35);
  assign s6_accb_nxt = {{22{s5_vp2_r[41]}}, s5_vp2_r} << 12;

  // stage 7: sums
  assign s7_v2_nxt   = s6_v2a_r + s6_v2b_r;
  assign s7_acc0_nxt = 64'($signed(s6_acca_r) >>> 8) + s6_accb_r;

  // stage 8: divisor product and numerator difference
  assign s8_accm_nxt = (s7_acc0_r + 64'h0000_8000_0000_0000) * {48'd0, coef.p1};
  assign s8_numa_nxt = ({43'd0, s7_pp_r} << 31) - s7_v2_r;

  // stage 9: divider operands
  assign s9_den_nxt  = 64'($signed(s8_accm_r) >>> 33);
  assign s9_zero_nxt = (s8_accm_r[DataW-1:33] == '0);
  assign s9_num_nxt  = s8_numa_r * 64'(DivScale);

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:0], in_valid};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s1_a1p_r  <= s1_a1p_nxt;
    s1_dd_r   <= dd_full[32:0];
    s1_pp_r   <= s1_pp_nxt;
    s2_a1_r   <= s1_a1p_r[34:11];
    s2_a2p_r  <= s2_a2p_nxt;
    s2_pp_r   <= s1_pp_r;
    s3_fine_r <= s3_fine_nxt;
    s3_pp_r   <= s2_pp_r;
    s4_tc_r   <= s4_tc_nxt;
    s4_v1_r   <= s4_v1_nxt;
    s4_pp_r   <= s3_pp_r;
    s5_vv_r   <= s5_vv_nxt;
    s5_vp5_r  <= s5_vp5_nxt;
    s5_vp2_r  <= s5_vp2_nxt;
    s5_tc_r   <= s4_tc_r;
    s5_pp_r   <= s4_pp_r;
    s6_v2a_r  <= s6_v2a_nxt;
    s6_v2b_r  <= s6_v2b_nxt;
    s6_acca_r <= s6_acca_nxt;
    s6_accb_r <= s6_accb_nxt;
    s6_tc_r   <= s5_tc_r;
    s6_pp_r   <= s5_pp_r;
    s7_v2_r   <= s7_v2_nxt;
    s7_acc0_r <= s7_acc0_nxt;
    s7_tc_r   <= s6_tc_r;
    s7_pp_r   <= s6_pp_r;
    s8_accm_r <= s8_accm_nxt;
    s8_numa_r <= s8_numa_nxt;
    s8_tc_r   <= s7_tc_r;
    s9_num_r  <= s9_num_nxt;
    s9_den_r  <= s9_den_nxt;
    s9_zero_r <= s9_zero_nxt;
    s9_tc_r   <= s8_tc_r;
  end

  // operands to the divider
  always_comb begin
    div_in.valid    = vld_r[8];
    div_in.num      = s9_num_r;
    div_in.den      = s9_den_r;
    div_in.tag.tc   = s9_tc_r;
    div_in.tag.zero = s9_zero_r;
  end

endmodule

// ===== rtl/core/ptc_div.sv =====
// pipelined signed 64-bit divider, one quotient bit per stage, truncating
// toward zero; carries a ptc_tag_t alongside; uses ptc_pkg
`timescale 1ns / 1ps

module ptc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptc_pkg::ptc_div_in_t  div_in,
  output ptc_pkg::ptc_div_out_t div_out
);
  import ptc_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] dq;
    logic [DataW-1:0] mb;
    logic             neg;
    ptc_tag_t         tag;
  } div_stage_t;

  // one restoring step: shift in a dividend bit, subtract when it fits
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t n;
    logic [DataW:0] r;
    logic [DataW:0] diff;
    n    = s;
    r    = {s.rem, s.dq[DataW-1]};
    diff = r - {1'b0, s.mb};
    if (!diff[DataW]) begin
      n.rem = diff[DataW-1:0];
      n.dq  = {s.dq[DataW-2:0], 1'b1};
    end else begin
      n.rem = r[DataW-1:0];
      n.dq  = {s.dq[DataW-2:0], 1'b0};
    end
    return n;
  endfunction

  div_stage_t         st_r [DivSteps+1];
  logic [DivSteps:0]  vld_r;
  div_stage_t         pre_nxt;
  logic [DataW-1:0]   quo_nxt, quo_r;
  ptc_tag_t           tag_r;
  logic               out_vld_r;

  // magnitudes and result sign
  always_comb begin
    pre_nxt.rem = '0;
    pre_nxt.dq  = div_in.num[DataW-1] ? (64'd0 - div_in.num) : div_in.num;
    pre_nxt.mb  = div_in.den[DataW-1] ? (64'd0 - div_in.den) : div_in.den;
    pre_nxt.neg = div_in.num[DataW-1] ^ div_in.den[DataW-1];
    pre_nxt.tag = div_in.tag;
  end

  assign quo_nxt = st_r[DivSteps].neg ? (64'd0 - st_r[DivSteps].dq) : st_r[DivSteps].dq;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[DivSteps-1:0], div_in.valid};
      out_vld_r <= vld_r[DivSteps];
    end
  end

  // step registers
  always_ff @(posedge clk) begin
    st_r[0] <= pre_nxt;
    for (int k = 0; k < DivSteps; k++) begin
      st_r[k+1] <= div_step(st_r[k]);
    end
    quo_r <= quo_nxt;
    tag_r <= st_r[DivSteps].tag;
  end

  assign div_out.valid = out_vld_r;
  assign div_out.quo   = quo_r;
  assign div_out.tag   = tag_r;

endmodule

// ===== rtl/core/ptc_back.sv =====
// back end: pressure correction after the division, saturation and the
// plausibility check; uses ptc_pkg
`timescale 1ns / 1ps

module ptc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ptc_pkg::ptc_div_out_t        div_out,
  input  ptc_pkg::ptc_coef_t           coef,
  input  ptc_pkg::ptc_limits_t         limits,
  output logic                         out_valid,
  output logic signed [ptc_pkg::TempW-1:0] out_temp,
  output logic [ptc_pkg::PressW-1:0]   out_press,
  output logic                         out_bad
);
  import ptc_pkg::*;

  logic [5:0] vld_r;

  logic [DataW-1:0] x_nxt;
  logic [DataW-1:0] b1_q_r, b1_x_r, b1_y_r, b1_w2p_r;
  ptc_tag_t         b1_tag_r;
  logic [DataW-1:0] b2_ll_r, b2_q_r, b2_w2_r;
  logic [31:0]      b2_lh_r, b2_hl_r;
  ptc_tag_t         b2_tag_r;
  logic [DataW-1:0] prod;
  logic [DataW-1:0] b3_w1_r, b3_q_r, b3_w2_r;
  ptc_tag_t         b3_tag_r;
  logic [DataW-1:0] b4_s_r;
  ptc_tag_t         b4_tag_r;
  logic [DataW-1:0] p_fin;
  logic [PressW-1:0] b5_pq_nxt, b5_pq_r;
  ptc_tag_t         b5_tag_r;
  logic             bad_nxt;
  logic signed [TempW-1:0] temp_r;
  logic [PressW-1:0] press_r;
  logic             bad_r;

  // stage 1: shifted quotient and its first products
  assign x_nxt = 64'($signed(div_out.quo) >>> 13);

  // stage 3: 64-bit product from partial products
  assign prod = b2_ll_r + {b2_lh_r + b2_hl_r, 32'd0};

  // stage 5: final pressure and saturation
  assign p_fin = 64'($signed(b4_s_r) >>> 8) + {{44{coef.p7[15]}}, coef.p7, 4'b0000};
  always_comb begin
    if (b4_tag_r.zero || p_fin[DataW-1]) begin
      b5_pq_nxt = '0;
    end else if (p_fin[DataW-1:PressW] != '0) begin
      b5_pq_nxt = '1;
    end else begin
      b5_pq_nxt = p_fin[PressW-1:0];
    end
  end

  // stage 6: plausibility window
  assign bad_nxt = (b5_tag_r.tc < TempW'(limits.temp_lo)) ||
                   (b5_tag_r.tc > TempW'(limits.temp_hi)) ||
                   (b5_pq_r < limits.press_lo) || (b5_pq_r > limits.press_hi);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], div_out.valid};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    b1_q_r   <= div_out.quo;
    b1_x_r   <= x_nxt;
    b1_y_r   <= mul_lo64_s16(x_nxt, coef.p9);
    b1_w2p_r <= mul_lo64_s16(div_out.quo, coef.p8);
    b1_tag_r <= div_out.tag;
    b2_ll_r  <= 64'(b1_y_r[31:0]) * 64'(b1_x_r[31:0]);
    b2_lh_r  <= b1_y_r[31:0] * b1_x_r[63:32];
    b2_hl_r  <= b1_y_r[63:32] * b1_x_r[31:0];
    b2_w2_r  <= 64'($signed(b1_w2p_r) >>> 19);
    b2_q_r   <= b1_q_r;
    b2_tag_r <= b1_tag_r;
    b3_w1_r  <= 64'($signed(prod) >>> 25);
    b3_q_r   <= b2_q_r;
    b3_w2_r  <= b2_w2_r;
    b3_tag_r <= b2_tag_r;
    b4_s_r   <= b3_q_r + b3_w1_r + b3_w2_r;
    b4_tag_r <= b3_tag_r;
    b5_pq_r  <= b5_pq_nxt;
    b5_tag_r <= b4_tag_r;
    temp_r   <= b5_tag_r.tc;
    press_r  <= b5_pq_r;
    bad_r    <= bad_nxt;
  end

  assign out_valid = vld_r[5];
  assign out_temp  = temp_r;
  assign out_press = press_r;
  assign out_bad   = bad_r;

endmodule

// ===== verif/ptc_checker.sv =====
// checker for the barometric compensation block: tracks register writes,
// predicts each word's result and compares it; uses ptc_pkg
`timescale 1ns / 1ps

module ptc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [ptc_pkg::RawW-1:0]         in_raw_temperature,
  input  logic [ptc_pkg::RawW-1:0]         in_raw_pressure,
  input  logic                             out_valid,
  input  logic signed [ptc_pkg::TempW-1:0] out_temperature_centi,
  input  logic [ptc_pkg::PressW-1:0]       out_pressure_q8,
  input  logic                             out_abnormal,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [ptc_pkg::AddrW-1:0]        paddr,
  input  logic [ptc_pkg::DataW-1:0]        pwdata,
  output int                               mismatches,
  output int                               pending
);
  import ptc_pkg::*;

  typedef struct {
    logic signed [TempW-1:0] temp;
    logic [PressW-1:0]       press;
    logic                    abnormal;
  } reading_t;

  // shadow copy of the register file
  logic [47:0]        coef_t, coef_a, coef_b, coef_c;
  logic signed [15:0] temp_lo, temp_hi;
  logic [31:0]        press_lo, press_hi;

  reading_t expected_readings[$];

  assign pending = expected_readings.size();

  function automatic longint sw(logic [47:0] r, int k);
    logic [15:0] w;
    w = r[16*k +: 16];
    return longint'($signed(w));
  endfunction

  // integer compensation, 64-bit wrapping for the pressure path
  function automatic reading_t compensate(logic [RawW-1:0] rt, logic [RawW-1:0] rp);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint x, d, fine, tc, v1, v2, acc, num, p, w1, w2;
    logic [PressW-1:0] pq;
    reading_t r;
    t1 = longint'(coef_t[15:0]);
    t2 = sw(coef_t, 1);
    t3 = sw(coef_t, 2);
    p1 = longint'(coef_a[15:0]);
    p2 = sw(coef_a, 1);
    p3 = sw(coef_a, 2);
    p4 = sw(coef_b, 0);
    p5 = sw(coef_b, 1);
    p6 = sw(coef_b, 2);
    p7 = sw(coef_c, 0);
    p8 = sw(coef_c, 1);
    p9 = sw(coef_c, 2);
    // temperature
    x = longint'(rt >> 3) - 2 * t1;
    d = longint'(rt >> 4) - t1;
    fine = ((x * t2) >>> 11) + ((((d * d) >>> 12) * t3) >>> 14);
    tc = (fine * 5 + 128) >>> 8;
    if (tc > 8388607) tc = 8388607;
    if (tc < -8388608) tc = -8388608;
    // pressure
    v1 = fine - FineOffset;
    v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * (longint'(1) <<< 35);
    acc = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
    acc = (((longint'(1) <<< 47) + acc) * p1) >>> 33;
    pq = '0;
    if (acc != 0) begin
      p = longint'(PressBase) - longint'(rp);
      num = ((p <<< 31) - v2) * DivScale;
      // most negative / -1 wraps to itself
      if (acc == -1) p = -num;
      else p = num / acc;
      w1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + p7 * 16;
      if (p < 0) pq = '0;
      else if (p > 64'sh0_FFFF_FFFF) pq = '1;
      else pq = p[31:0];
    end
    r.temp = tc[TempW-1:0];
    r.press = pq;
    r.abnormal = (tc < longint'(temp_lo)) || (tc > longint'(temp_hi)) ||
                 (pq < press_lo) || (pq > press_hi);
    return r;
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_t <= '0;
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      temp_lo <= 16'(TempLoReset);
      temp_hi <= 16'(TempHiReset);
      press_lo <= 32'(PressLoReset);
      press_hi <= 32'(PressHiReset);
    end else if (psel && penable && pwrite && pready) begin
      case (ptc_reg_t'(paddr[5:3]))
        REG_TEMP_COEFFS: coef_t <= pwdata[47:0];
        REG_PRESS_A:     coef_a <= pwdata[47:0];
        REG_PRESS_B:     coef_b <= pwdata[47:0];
        REG_PRESS_C:     coef_c <= pwdata[47:0];
        REG_TEMP_LO:     temp_lo <= pwdata[15:0];
        REG_TEMP_HI:     temp_hi <= pwdata[15:0];
        REG_PRESS_LO:    press_lo <= pwdata[31:0];
        REG_PRESS_HI:    press_hi <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // predict on accepted words, compare on result words
  always @(posedge clk) begin
    reading_t e;
    if (!rst_n) begin
      mismatches = 0;
    end else begin
      if (start && !busy)
        expected_readings.push_back(compensate(in_raw_temperature, in_raw_pressure));
      if (out_valid) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result word t=%0d p=%0d ab=%0b", $time,
                   out_temperature_centi, out_pressure_q8, out_abnormal);
          mismatches++;
        end else begin
          e = expected_readings.pop_front();
          if (out_temperature_centi !== e.temp) begin
            $display("%0t: temperature expected %0d actual %0d", $time, e.temp,
                     out_temperature_centi);
            mismatches++;
          end
          if (out_pressure_q8 !== e.press) begin
            $display("%0t: pressure expected %0d actual %0d", $time, e.press,
                     out_pressure_q8);
            mismatches++;
          end
          if (out_abnormal !== e.abnormal) begin
            $display("%0t: abnormal expected %0b actual %0b", $time, e.abnormal,
                     out_abnormal);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the barometric compensation block: clock, reset,
// register phases and word stimulus; uses ptc_pkg, ptc_checker and the RTL
`timescale 1ns / 1ps

module tb_top;
  import ptc_pkg::*;

  localparam int Latency = 90;
  localparam int StallLimit = 5000;

  logic clk, rst_n, start, busy;
  logic [RawW-1:0] in_raw_temperature, in_raw_pressure;
  logic out_valid, out_abnormal;
  logic signed [TempW-1:0] out_temperature_centi;
  logic [PressW-1:0] out_pressure_q8;
  logic psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  int mismatches, pending;
  int quiet_cycles;
  bit allow_idle;

  pressure_temp_compensation u_dut (.*);

  ptc_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(ptc_reg_t idx, logic [DataW-1:0] value);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= AddrW'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic send_word(logic [RawW-1:0] rt, logic [RawW-1:0] rp);
    in_raw_temperature <= rt;
    in_raw_pressure <= rp;
    start <= 1;
    do @(posedge clk); while (busy);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic set_coeffs(logic [47:0] ct, logic [47:0] ca, logic [47:0] cb,
                            logic [47:0] cc);
    reg_write(REG_TEMP_COEFFS, {16'h0, ct});
    reg_write(REG_PRESS_A, {16'h0, ca});
    reg_write(REG_PRESS_B, {16'h0, cb});
    reg_write(REG_PRESS_C, {16'h0, cc});
  endtask

  task automatic set_limits(logic [15:0] tlo, logic [15:0] thi, logic [31:0] plo,
                            logic [31:0] phi);
    reg_write(REG_TEMP_LO, {$urandom, $urandom} & ~64'hFFFF | 64'(tlo));
    reg_write(REG_TEMP_HI, 64'(thi));
    reg_write(REG_PRESS_LO, {$urandom, plo});
    reg_write(REG_PRESS_HI, 64'(phi));
  endtask

  // random words: mostly near typical readings, some anywhere
  task automatic random_words(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0)
        send_word(RawW'(519888 + $signed($urandom_range(0, 160000)) - 80000),
                  RawW'(415148 + $signed($urandom_range(0, 160000)) - 80000));
      else
        send_word(RawW'($urandom), RawW'($urandom));
    end
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  // typical calibration set
  localparam logic [47:0] TypT = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] TypA = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [47:0] TypB = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [47:0] TypC = {16'd6000, 16'hC6F8, 16'd15500};

  initial begin
    rst_n = 0;
    start = 0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    allow_idle = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset registers: zero coefficients give a zero divisor
    send_word('0, '0);
    send_word('1, '1);
    send_word(20'd519888, 20'd415148);
    drain();

    // directed with typical calibration
    set_coeffs(TypT, TypA, TypB, TypC);
    send_word(20'd519888, 20'd415148);
    send_word('0, '0);
    send_word('1, '1);
    send_word('0, '1);
    send_word('1, '0);
    send_word(20'h55555, 20'hAAAAA);
    send_word(20'hAAAAA, 20'h55555);
    send_word(20'd600000, 20'd300000);
    drain();

    // extreme calibration words
    set_coeffs('1, '1, '1, '1);
    send_word('0, '0);
    send_word('1, '1);
    send_word(20'd519888, 20'd415148);
    drain();
    set_coeffs({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send_word('0, '0);
    send_word('1, '1);
    send_word(20'd519888, 20'd415148);
    drain();
    set_coeffs({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send_word('0, '0);
    send_word('1, '1);
    drain();

    // wide-open limits, then crossed limits
    set_limits(16'h8000, 16'h7FFF, 32'h0, 32'hFFFF_FFFF);
    set_coeffs(TypT, TypA, TypB, TypC);
    allow_idle = 1;
    random_words(250);
    drain();
    set_limits(16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 32'h0);
    random_words(200);
    drain();

    // tight limits around typical readings
    set_limits(16'd2000, 16'd3000, 32'd25000000, 32'd26000000);
    random_words(250);
    drain();

    // random calibration with random limits
    for (int ph = 0; ph < 4; ph++) begin
      set_coeffs(rand48(), rand48(), rand48(), rand48());
      set_limits(16'($urandom), 16'($urandom), $urandom, $urandom);
      random_words(150);
      drain();
    end

    // typical calibration, p1 zeroed, and a final run with no idling
    set_coeffs(TypT, {TypA[47:16], 16'h0}, TypB, TypC);
    random_words(50);
    drain();
    set_coeffs(TypT, TypA, TypB, rand48());
    set_limits(16'hFC18, 16'd5000, 32'd23040000, 32'd28160000);
    random_words(150);
    allow_idle = 0;
    random_words(200);
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
